// ===== rtl/cgm_pkg.sv =====
`timescale 1ns / 1ps
// cgm_pkg: shared types and constants of the coverage grid marker
// depends on nothing; imported by coverage_grid_marker and the bench files
package cgm_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIV_X,
      ST_DIV_Y,
      ST_REACH,
      ST_CELL_A,
      ST_CELL_B,
      ST_CELL_C,
      ST_FIN_RD,
      ST_FIN_WT,
      ST_RW_RD,
      ST_RW_WT,
      ST_DONE
   } state_type;

   localparam logic [1:0] CELL_UNKNOWN = 2'd0;
   localparam logic [1:0] CELL_WALL    = 2'd1;
   localparam logic [1:0] CELL_VISITED = 2'd2;

   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_POINT  = 3'd1;
   localparam logic [2:0] ACT_RADIUS = 3'd2;
   localparam logic [2:0] ACT_READ   = 3'd3;
   localparam logic [2:0] ACT_WRITE  = 3'd4;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_CELL_MM  = 3'd2;
   localparam logic [2:0] REG_COLS     = 3'd3;
   localparam logic [2:0] REG_ROWS     = 3'd4;

   localparam int POS_W     = 21;
   localparam int CELL_MM_W = 16;
   localparam int DIM_W     = 7;
   localparam int CNT_W     = 13;
   localparam int IDX_OUT_W = 6;
   localparam int DIV_STEPS = 21;

   localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;

endpackage

// ===== rtl/coverage_grid_marker.sv =====
`timescale 1ns / 1ps
// coverage_grid_marker: occupancy grid coverage map with one cell memory
// depends on cgm_pkg
//
// One transaction is worked at a time; the next is taken while a result
// still waits in the output register. Clear writes one cell a cycle over
// all w*h cells (w, h the dimensions in use). Both mark actions first
// run a shared serial divider twice to find the centre cell. mark_radius
// then walks up to MAX_REACH steps to find the walked half-size rc and
// visits each cell of the (2*rc+1)^2 square with one memory read, one
// distance step and one write back. The cell memory holds no defined
// value until a clear covers it.
module coverage_grid_marker #(
   parameter int MAX_COLS   = 64,
   parameter int MAX_ROWS   = 64,
   parameter int MAX_REACH  = 8,
   parameter int WALL_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x_mm[20:0], pos_y_mm[41:21], reach_mm[57:42], col_req[65:58],
   // row_req[73:66], new_state[75:74], zero fill
   input  logic [cgm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action[2:0]
   input  logic [cgm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_state[1:0], col_out[7:2], row_out[13:8], visited_total[26:14],
   // open_total[39:27]
   output logic [cgm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cgm_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [cgm_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [cgm_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import cgm_pkg::*;

   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int KW    = $clog2(MAX_REACH + 1);
   localparam int OW    = KW + 1;
   localparam int GW    = ((CW > OW) ? CW : OW) + 2;
   localparam int EXW   = GW + 20;

   // configuration registers
   logic signed [POS_W-1:0] ox_ff, oy_ff;
   logic [CELL_MM_W-1:0]    cellmm_ff;
   logic [DIM_W-1:0]        cols_ff, rows_ff;

   logic                    cfg_we;
   logic [2:0]              cfg_idx;

   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[4:2];
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff     <= '0;
         oy_ff     <= '0;
         cellmm_ff <= 16'd100;
         cols_ff   <= '0;
         rows_ff   <= '0;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            REG_ORIGIN_X: ox_ff     <= csr_pwdata[POS_W-1:0];
            REG_ORIGIN_Y: oy_ff     <= csr_pwdata[POS_W-1:0];
            REG_CELL_MM:  cellmm_ff <= csr_pwdata[CELL_MM_W-1:0];
            REG_COLS:     cols_ff   <= csr_pwdata[DIM_W-1:0];
            REG_ROWS:     rows_ff   <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_ORIGIN_X: csr_prdata = CSR_DW'(ox_ff);
         REG_ORIGIN_Y: csr_prdata = CSR_DW'(oy_ff);
         REG_CELL_MM:  csr_prdata = CSR_DW'(cellmm_ff);
         REG_COLS:     csr_prdata = CSR_DW'(cols_ff);
         REG_ROWS:     csr_prdata = CSR_DW'(rows_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // effective geometry
   logic [DIM_W-1:0]     w_eff, h_eff;
   logic [CELL_MM_W-1:0] cs;
   logic                 grid_empty;

   assign w_eff = (cols_ff > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_ff;
   assign h_eff = (rows_ff > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign cs    = (cellmm_ff == '0) ? CELL_MM_W'(1) : cellmm_ff;
   assign grid_empty = (w_eff == '0) || (h_eff == '0);

   // request fields
   logic [2:0]              in_act;
   logic signed [POS_W-1:0] in_px, in_py;
   logic [15:0]             in_reach;
   logic [7:0]              in_col, in_row;
   logic [1:0]              in_nst;

   assign in_act   = req_tuser[2:0];
   assign in_px    = req_tdata[20:0];
   assign in_py    = req_tdata[41:21];
   assign in_reach = req_tdata[57:42];
   assign in_col   = req_tdata[65:58];
   assign in_row   = req_tdata[73:66];
   assign in_nst   = req_tdata[75:74];

   logic signed [21:0] dpx, dpy;
   assign dpx = 22'(in_px) - 22'(ox_ff);
   assign dpy = 22'(in_py) - 22'(oy_ff);

   // state and datapath registers
   state_type state_ff, state_in;

   logic [2:0]              act_ff;
   logic [15:0]             reach_ff;
   logic [1:0]              nst_ff;
   logic                    rw_inb_ff;
   logic                    negx_ff, negy_ff;
   logic [20:0]             divy_ff;
   logic signed [23:0]      bx_ff, by_ff;
   logic [20:0]             quo_ff;
   logic [15:0]             rem_ff;
   logic [4:0]              cnt_ff;
   logic [CW-1:0]           cc_ff, x_ff;
   logic [RW-1:0]           cr_ff, y_ff;
   logic [KW-1:0]           k_ff;
   logic [21:0]             acc_ff;
   logic [33:0]             lim_ff;
   logic signed [OW-1:0]    offx_ff, offy_ff;
   logic                    nodist_ff;
   logic [AW-1:0]           addr_ff;
   logic                    inb_ff;
   logic signed [EXW-1:0]   ex_ff, ey_ff;
   logic                    far_ff;
   logic [33:0]             sqx_ff, sqy_ff;
   logic [1:0]              rdata_ff;
   logic [CNT_W-1:0]        visited_ff, open_ff;
   logic [1:0]              res_state_ff;
   logic [IDX_OUT_W-1:0]    res_col_ff, res_row_ff;
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;

   logic [1:0] mem [DEPTH];

   // serial divider step
   logic [16:0] div_t;
   logic        div_ge;
   logic [15:0] rem_in;
   logic [20:0] quo_in;
   logic        div_last;

   assign div_t    = {rem_ff, quo_ff[20]};
   assign div_ge   = div_t >= {1'b0, cs};
   assign rem_in   = div_ge ? 16'(div_t - {1'b0, cs}) : div_t[15:0];
   assign quo_in   = {quo_ff[19:0], div_ge};
   assign div_last = cnt_ff == 5'(DIV_STEPS - 1);

   function automatic logic [DIM_W-1:0] clamp_idx(input logic [20:0] q, input logic neg,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (neg || lim == '0)
         r = '0;
      else if (q >= 21'(lim))
         r = lim - 1'b1;
      else
         r = q[DIM_W-1:0];
      return r;
   endfunction

   // cell walk
   logic signed [OW-1:0]     k_s;
   logic signed [GW-1:0]     gx, gy;
   logic                     inb_a;
   logic signed [GW+16:0]    prodx, prody;
   logic signed [EXW-1:0]    ex_in, ey_in;
   logic [EXW-1:0]           aex, aey;
   logic [16:0]              reach2;
   logic                     reach_done;
   logic                     cell_last;
   logic                     near;
   logic                     rdx_last;

   assign k_s    = $signed({1'b0, k_ff});
   assign gx     = GW'($signed({1'b0, cc_ff})) + GW'(offx_ff);
   assign gy     = GW'($signed({1'b0, cr_ff})) + GW'(offy_ff);
   assign inb_a  = !gx[GW-1] && !gy[GW-1] &&
                   (gx < $signed(GW'(w_eff))) && (gy < $signed(GW'(h_eff)));
   assign prodx  = gx * $signed({1'b0, cs});
   assign prody  = gy * $signed({1'b0, cs});
   assign ex_in  = EXW'(bx_ff) + (EXW'(prodx) <<< 1);
   assign ey_in  = EXW'(by_ff) + (EXW'(prody) <<< 1);
   assign aex    = ex_ff[EXW-1] ? EXW'(-ex_ff) : EXW'(ex_ff);
   assign aey    = ey_ff[EXW-1] ? EXW'(-ey_ff) : EXW'(ey_ff);
   assign reach2 = {reach_ff, 1'b0};
   assign reach_done = !((k_ff < KW'(MAX_REACH)) && (acc_ff < 22'(reach_ff)));
   assign rdx_last   = offx_ff == k_s;
   assign cell_last  = rdx_last && (offy_ff == k_s);
   assign near = nodist_ff ||
                 (!far_ff && ({1'b0, sqx_ff} + {1'b0, sqy_ff} <= {1'b0, lim_ff}));

   // clear sweep
   logic clear_wall, clear_xlast, clear_last;

   assign clear_wall  = (8'(x_ff) < 8'(WALL_DEPTH)) ||
                        (9'(x_ff) + 9'(WALL_DEPTH) >= 9'(w_eff)) ||
                        (8'(y_ff) < 8'(WALL_DEPTH)) ||
                        (9'(y_ff) + 9'(WALL_DEPTH) >= 9'(h_eff));
   assign clear_xlast = 9'(x_ff) + 9'd1 == 9'(w_eff);
   assign clear_last  = clear_xlast && (9'(y_ff) + 9'd1 == 9'(h_eff));

   // write back of single cells
   logic rw_write;
   assign rw_write = (act_ff == ACT_WRITE) && rw_inb_ff && (nst_ff != 2'd3);

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (in_act) inside
                  ACT_CLEAR:             state_in = ST_CLEAR;
                  ACT_POINT, ACT_RADIUS: state_in = ST_DIV_X;
                  ACT_READ, ACT_WRITE:   state_in = ST_RW_RD;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR:  if (grid_empty || clear_last) state_in = ST_DONE;
         ST_DIV_X:  if (div_last) state_in = ST_DIV_Y;
         ST_DIV_Y: begin
            if (div_last) state_in = (act_ff == ACT_RADIUS) ? ST_REACH : ST_CELL_A;
         end
         ST_REACH:  if (reach_done) state_in = ST_CELL_A;
         ST_CELL_A: state_in = ST_CELL_B;
         ST_CELL_B: state_in = ST_CELL_C;
         ST_CELL_C: state_in = cell_last ? ST_FIN_RD : ST_CELL_A;
         ST_FIN_RD: state_in = ST_FIN_WT;
         ST_FIN_WT: state_in = ST_DONE;
         ST_RW_RD:  state_in = ST_RW_WT;
         ST_RW_WT:  state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [1:0]      mem_wdata;
   logic            mark_we;

   assign mark_we = inb_ff && near && (rdata_ff == CELL_UNKNOWN);

   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = addr_ff;
      mem_wdata  = CELL_VISITED;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_CLEAR: begin
            mem_we    = !grid_empty;
            mem_waddr = {y_ff, x_ff};
            mem_wdata = clear_wall ? CELL_WALL : CELL_UNKNOWN;
         end
         ST_CELL_C: mem_we = mark_we;
         ST_RW_WT: begin
            mem_we    = rw_write;
            mem_wdata = nst_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cell memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         visited_ff   <= '0;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  act_ff       <= in_act;
                  reach_ff     <= in_reach;
                  nst_ff       <= in_nst;
                  negx_ff      <= dpx[21];
                  negy_ff      <= dpy[21];
                  divy_ff      <= dpy[20:0];
                  quo_ff       <= dpx[20:0];
                  rem_ff       <= '0;
                  cnt_ff       <= '0;
                  bx_ff        <= 24'(cs) - {dpx[21], dpx, 1'b0};
                  by_ff        <= 24'(cs) - {dpy[21], dpy, 1'b0};
                  rw_inb_ff    <= !in_col[7] && !in_row[7] &&
                                  (in_col[6:0] < w_eff) && (in_row[6:0] < h_eff);
                  addr_ff      <= {RW'(in_row), CW'(in_col)};
                  x_ff         <= '0;
                  y_ff         <= '0;
                  acc_ff       <= '0;
                  k_ff         <= '0;
                  res_state_ff <= CELL_UNKNOWN;
                  if (in_act == ACT_CLEAR) begin
                     visited_ff <= '0;
                     open_ff    <= '0;
                  end
                  if (in_act == ACT_READ || in_act == ACT_WRITE) begin
                     res_col_ff <= in_col[IDX_OUT_W-1:0];
                     res_row_ff <= in_row[IDX_OUT_W-1:0];
                  end else begin
                     res_col_ff <= '0;
                     res_row_ff <= '0;
                  end
               end
            end
            ST_CLEAR: begin
               if (!grid_empty) begin
                  if (!clear_wall && open_ff != CNT_MAX) open_ff <= open_ff + 1'b1;
                  if (clear_xlast) begin
                     x_ff <= '0;
                     y_ff <= y_ff + 1'b1;
                  end else begin
                     x_ff <= x_ff + 1'b1;
                  end
               end
            end
            ST_DIV_X: begin
               if (div_last) begin
                  cc_ff  <= CW'(clamp_idx(quo_in, negx_ff, w_eff));
                  quo_ff <= divy_ff;
                  rem_ff <= '0;
                  cnt_ff <= '0;
               end else begin
                  rem_ff <= rem_in;
                  quo_ff <= quo_in;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIV_Y: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (div_last) begin
                  cr_ff     <= RW'(clamp_idx(quo_in, negy_ff, h_eff));
                  offx_ff   <= '0;
                  offy_ff   <= '0;
                  nodist_ff <= 1'b1;
               end
            end
            ST_REACH: begin
               lim_ff <= {17'd0, reach2} * {17'd0, reach2};
               if (reach_done) begin
                  offx_ff   <= -k_s;
                  offy_ff   <= -k_s;
                  nodist_ff <= 1'b0;
               end else begin
                  acc_ff <= acc_ff + 22'(cs);
                  k_ff   <= k_ff + 1'b1;
               end
            end
            ST_CELL_A: begin
               inb_ff  <= inb_a;
               addr_ff <= {gy[RW-1:0], gx[CW-1:0]};
               ex_ff   <= ex_in;
               ey_ff   <= ey_in;
            end
            ST_CELL_B: begin
               far_ff <= (aex > EXW'(reach2)) || (aey > EXW'(reach2));
               sqx_ff <= aex[16:0] * aex[16:0];
               sqy_ff <= aey[16:0] * aey[16:0];
            end
            ST_CELL_C: begin
               if (mark_we && visited_ff != CNT_MAX) visited_ff <= visited_ff + 1'b1;
               if (cell_last) begin
                  addr_ff <= {cr_ff, cc_ff};
               end else if (rdx_last) begin
                  offx_ff <= -k_s;
                  offy_ff <= offy_ff + 1'b1;
               end else begin
                  offx_ff <= offx_ff + 1'b1;
               end
            end
            ST_FIN_WT: begin
               res_state_ff <= grid_empty ? CELL_WALL : rdata_ff;
               res_col_ff   <= IDX_OUT_W'(cc_ff);
               res_row_ff   <= IDX_OUT_W'(cr_ff);
            end
            ST_RW_WT: begin
               if (!rw_inb_ff)
                  res_state_ff <= CELL_WALL;
               else if (rw_write)
                  res_state_ff <= nst_ff;
               else
                  res_state_ff <= rdata_ff;
               if (rw_write) begin
                  if (rdata_ff == CELL_VISITED && nst_ff != CELL_VISITED) begin
                     if (visited_ff != '0) visited_ff <= visited_ff - 1'b1;
                  end else if (rdata_ff != CELL_VISITED && nst_ff == CELL_VISITED) begin
                     if (visited_ff != CNT_MAX) visited_ff <= visited_ff + 1'b1;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_data_ff  <= {open_ff, visited_ff, res_row_ff, res_col_ff,
                                   res_state_ff};
               end
            end
            default: ;
         endcase
      end
   end

   // memory is written only by the clear sweep, the cell walk and single writes
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_CELL_C || state_ff == ST_RW_WT))
      else $error("cell memory written outside a write state");

   // a finished result with a free output register is shown next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not delivered to output register");

   // the end of a clear leaves no visited cells
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && state_in == ST_DONE) |=> visited_ff == '0)
      else $error("visited count not zero after clear");

   // marking a cell raises the count by one unless saturated
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL_C && mark_we) |=>
         (visited_ff == $past(visited_ff) + 1'b1 || $past(visited_ff) == CNT_MAX))
      else $error("visited count not advanced on mark");

   // a new transaction is taken only with the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff != ST_IDLE)
      else $error("sequencer did not leave idle on transaction");

endmodule

// ===== bench/coverage_grid_marker_check.sv =====
`timescale 1ns / 1ps
// coverage_grid_marker_check: watches the request, response and csr ports,
// predicts each response of the grid map and compares; depends on cgm_pkg
module coverage_grid_marker_check
   import cgm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,
   input  logic [REQ_TUSER_W-1:0]   req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending
);

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;
   localparam int REACH_CAP = 8;
   localparam int BORDER    = 2;

   typedef struct packed {
      logic [12:0] open_total;
      logic [12:0] visited_total;
      logic [5:0]  row_out;
      logic [5:0]  col_out;
      logic [1:0]  cell_state;
   } grid_rsp_t;

   logic [1:0]  grid_model [GRID_COLS*GRID_ROWS];
   int unsigned visited_cnt, open_cnt;
   logic signed [20:0] org_x, org_y;
   logic [15:0] cell_size_mm;
   logic [6:0]  cols_reg, rows_reg;
   grid_rsp_t   rsp_queue[$];

   assign pending = rsp_queue.size();

   function automatic longint width_in_use();
      return (cols_reg > GRID_COLS) ? GRID_COLS : longint'(cols_reg);
   endfunction

   function automatic longint height_in_use();
      return (rows_reg > GRID_ROWS) ? GRID_ROWS : longint'(rows_reg);
   endfunction

   function automatic longint cell_side();
      return (cell_size_mm == 0) ? 1 : longint'(cell_size_mm);
   endfunction

   function automatic bit on_grid(longint c, longint r);
      return c >= 0 && r >= 0 && c < width_in_use() && r < height_in_use();
   endfunction

   function automatic logic [1:0] cell_at(longint c, longint r);
      if (!on_grid(c, r)) return CELL_WALL;
      return grid_model[r*GRID_COLS + c];
   endfunction

   task automatic put_cell(longint c, longint r, logic [1:0] st);
      logic [1:0] old;
      if (!on_grid(c, r)) return;
      old = grid_model[r*GRID_COLS + c];
      grid_model[r*GRID_COLS + c] = st;
      if (old == CELL_VISITED && st != CELL_VISITED) begin
         if (visited_cnt > 0) visited_cnt--;
      end else if (old != CELL_VISITED && st == CELL_VISITED) begin
         if (visited_cnt < 8191) visited_cnt++;
      end
   endtask

   task automatic visit_cell(longint c, longint r);
      if (on_grid(c, r) && cell_at(c, r) == CELL_UNKNOWN) put_cell(c, r, CELL_VISITED);
   endtask

   // floor division of the offset, clamped into the grid
   function automatic longint pos_to_index(longint pos, longint org, longint lim);
      longint d, cs, q;
      d = pos - org;
      cs = cell_side();
      q = d / cs;
      if (d % cs != 0 && d < 0) q--;
      if (q > lim - 1) q = lim - 1;
      if (q < 0) q = 0;
      return q;
   endfunction

   task automatic clear_grid_model();
      longint w, h;
      bit wall;
      int unsigned n_open;
      w = width_in_use();
      h = height_in_use();
      n_open = 0;
      for (longint y = 0; y < h; y++) begin
         for (longint x = 0; x < w; x++) begin
            wall = x < BORDER || x >= w - BORDER || y < BORDER || y >= h - BORDER;
            grid_model[y*GRID_COLS + x] = wall ? CELL_WALL : CELL_UNKNOWN;
            if (!wall) n_open++;
         end
      end
      open_cnt = (n_open > 8191) ? 8191 : n_open;
      visited_cnt = 0;
   endtask

   task automatic predict_grid_rsp(logic [2:0] act, logic [REQ_TDATA_W-1:0] d);
      grid_rsp_t exp_rsp;
      longint px, py, reach, creq, rreq, cc, cr, cs, rc, lim, gx, gy, ex, ey;
      logic [1:0] nst;
      px = longint'($signed(d[20:0]));
      py = longint'($signed(d[41:21]));
      reach = longint'(d[57:42]);
      creq = longint'($signed(d[65:58]));
      rreq = longint'($signed(d[73:66]));
      nst = d[75:74];
      exp_rsp = '0;
      if (act == ACT_CLEAR) begin
         clear_grid_model();
      end else if (act == ACT_POINT || act == ACT_RADIUS) begin
         cc = pos_to_index(px, longint'(org_x), width_in_use());
         cr = pos_to_index(py, longint'(org_y), height_in_use());
         if (act == ACT_POINT) begin
            visit_cell(cc, cr);
         end else begin
            cs = cell_side();
            rc = (reach + cs - 1) / cs;
            if (rc > REACH_CAP) rc = REACH_CAP;
            lim = (2*reach) * (2*reach);
            for (longint dy = -rc; dy <= rc; dy++) begin
               for (longint dx = -rc; dx <= rc; dx++) begin
                  gx = cc + dx;
                  gy = cr + dy;
                  if (on_grid(gx, gy)) begin
                     // distances in half-mm so the cell centre is exact
                     ex = 2*longint'(org_x) + (2*gx + 1)*cs - 2*px;
                     ey = 2*longint'(org_y) + (2*gy + 1)*cs - 2*py;
                     if (ex*ex + ey*ey <= lim) visit_cell(gx, gy);
                  end
               end
            end
         end
         exp_rsp.cell_state = cell_at(cc, cr);
         exp_rsp.col_out = cc[5:0];
         exp_rsp.row_out = cr[5:0];
      end else if (act == ACT_READ || act == ACT_WRITE) begin
         if (act == ACT_WRITE && nst <= CELL_VISITED) put_cell(creq, rreq, nst);
         exp_rsp.cell_state = cell_at(creq, rreq);
         exp_rsp.col_out = d[63:58];
         exp_rsp.row_out = d[71:66];
      end
      exp_rsp.visited_total = visited_cnt[12:0];
      exp_rsp.open_total = open_cnt[12:0];
      rsp_queue.push_back(exp_rsp);
   endtask

   always @(posedge clock) begin
      grid_rsp_t got, want;
      if (reset) begin
         visited_cnt = 0;
         open_cnt = 0;
         org_x = '0;
         org_y = '0;
         cell_size_mm = 16'd100;
         cols_reg = '0;
         rows_reg = '0;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_ORIGIN_X: org_x = csr_pwdata[20:0];
               REG_ORIGIN_Y: org_y = csr_pwdata[20:0];
               REG_CELL_MM:  cell_size_mm = csr_pwdata[15:0];
               REG_COLS:     cols_reg = csr_pwdata[6:0];
               REG_ROWS:     rows_reg = csr_pwdata[6:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (rsp_queue.size() == 0) begin
               $error("unexpected response transaction %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               if (got.cell_state !== want.cell_state)
                  $error("cell_state expected %0d got %0d", want.cell_state, got.cell_state);
               if (got.col_out !== want.col_out)
                  $error("col_out expected %0d got %0d", want.col_out, got.col_out);
               if (got.row_out !== want.row_out)
                  $error("row_out expected %0d got %0d", want.row_out, got.row_out);
               if (got.visited_total !== want.visited_total)
                  $error("visited_total expected %0d got %0d",
                         want.visited_total, got.visited_total);
               if (got.open_total !== want.open_total)
                  $error("open_total expected %0d got %0d", want.open_total, got.open_total);
               if (got !== want) fail_count <= fail_count + 1;
            end
         end
         if (req_tvalid && req_tready) predict_grid_rsp(req_tuser, req_tdata);
      end
   end

endmodule

// ===== bench/coverage_grid_marker_tb.sv =====
`timescale 1ns / 1ps
// coverage_grid_marker_tb: clock, reset, csr setup and request stimulus for
// the grid map; depends on cgm_pkg, coverage_grid_marker, coverage_grid_marker_check
module coverage_grid_marker_tb;
   import cgm_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata, csr_prdata;
   int fail_count, pending;
   int send_idle_pct, recv_stall_pct;
   longint grid_w, grid_h, org_x, org_y, cell_w;

   coverage_grid_marker dut (.*);
   coverage_grid_marker_check checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("coverage_grid_marker: mismatch");
      $finish;
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel = 1;
      csr_penable = 0;
      csr_pwrite = 1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
   endtask

   task automatic send_op(logic [2:0] act, longint px, longint py, longint reach,
                          longint col, longint row, logic [1:0] nst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = act;
      req_tdata = {4'b0, nst, 8'(row), 8'(col), 16'(reach), 21'(py), 21'(px)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // grid setup is always followed by a clear so no unwritten cell is read
   task automatic setup_grid(longint ox, longint oy, longint cs, longint cols, longint rows);
      drain();
      csr_write(REG_ORIGIN_X, 32'(ox));
      csr_write(REG_ORIGIN_Y, 32'(oy));
      csr_write(REG_CELL_MM, 32'(cs));
      csr_write(REG_COLS, 32'(cols));
      csr_write(REG_ROWS, 32'(rows));
      org_x = ox;
      org_y = oy;
      cell_w = (cs == 0) ? 1 : cs;
      grid_w = (cols > 64) ? 64 : cols;
      grid_h = (rows > 64) ? 64 : rows;
      send_op(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic random_op();
      int pick;
      logic [2:0] act;
      longint px, py, reach, col, row;
      logic [1:0] nst;
      pick = $urandom_range(99);
      if (pick < 2) act = ACT_CLEAR;
      else if (pick < 27) act = ACT_POINT;
      else if (pick < 57) act = ACT_RADIUS;
      else if (pick < 77) act = ACT_READ;
      else if (pick < 97) act = ACT_WRITE;
      else act = 3'($urandom_range(7, 5));
      if ($urandom_range(9) < 8) begin
         px = org_x - cell_w + longint'($urandom_range(32'((grid_w + 2) * cell_w)));
         py = org_y - cell_w + longint'($urandom_range(32'((grid_h + 2) * cell_w)));
         reach = longint'($urandom_range(32'(3 * cell_w)));
         if (reach > 65535) reach = 65535;
         col = longint'($urandom_range(32'(grid_w + 5))) - 3;
         row = longint'($urandom_range(32'(grid_h + 5))) - 3;
      end else begin
         px = longint'($urandom);
         py = longint'($urandom);
         reach = longint'($urandom);
         col = longint'($urandom);
         row = longint'($urandom);
      end
      nst = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      send_op(act, px, py, reach, col, row, nst);
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: corners, out of bounds, invalid state, extreme fields
      setup_grid(0, 0, 100, 16, 12);
      send_op(ACT_READ, 0, 0, 0, 0, 0, 0);
      send_op(ACT_READ, 0, 0, 0, 5, 5, 0);
      send_op(ACT_READ, 0, 0, 0, -1, 3, 0);
      send_op(ACT_READ, 0, 0, 0, 127, -128, 0);
      send_op(ACT_WRITE, 0, 0, 0, 6, 6, CELL_VISITED);
      send_op(ACT_WRITE, 0, 0, 0, 7, 6, 2'd3);
      send_op(ACT_WRITE, 0, 0, 0, 6, 6, CELL_WALL);
      send_op(ACT_WRITE, 0, 0, 0, 6, 6, CELL_UNKNOWN);
      send_op(ACT_WRITE, 0, 0, 0, -128, 127, CELL_VISITED);
      send_op(ACT_POINT, -1048576, 1048575, 0, 0, 0, 0);
      send_op(ACT_POINT, 1048575, -1048576, 0, 0, 0, 0);
      send_op(ACT_POINT, 550, 450, 0, 0, 0, 0);
      send_op(ACT_POINT, -1, -150, 0, 0, 0, 0);
      send_op(ACT_RADIUS, 800, 600, 0, 0, 0, 0);
      send_op(ACT_RADIUS, 800, 600, 250, 0, 0, 0);
      send_op(ACT_RADIUS, 800, 600, 65535, 0, 0, 0);
      send_op(3'd5, 1, 1, 1, 1, 1, 1);
      send_op(3'd6, 0, 0, 0, 0, 0, 0);
      send_op(3'd7, -1, -1, 65535, -1, -1, 2'd3);
      // empty grid: marks see a wall
      drain();
      csr_write(REG_COLS, 0);
      grid_w = 0;
      send_op(ACT_POINT, 300, 300, 0, 0, 0, 0);
      send_op(ACT_RADIUS, 300, 300, 200, 0, 0, 0);
      send_op(ACT_READ, 0, 0, 0, 0, 0, 0);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: setup_grid(0, 0, 100, 16, 12);
            1: setup_grid(-1048576, 1048575, 65535, 64, 64);
            2: setup_grid(12345, -777, 1, 4, 3);
            3: setup_grid(-500, 250, 0, 100, 127);
            default: setup_grid(1048575, -1048576, 37, 9, 5);
         endcase
         case (ph)
            1: begin send_idle_pct = 87; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 87; end
            3: begin send_idle_pct = 32; recv_stall_pct = 32; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat (150) random_op();
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end

      drain();
      repeat (1000) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("coverage_grid_marker: match");
      end else begin
         $display("coverage_grid_marker: mismatch");
      end
      $finish;
   end

endmodule
